[sv/sudl_pkg.sv]
// Types, constants and codes shared by the sorted descending list cells and top level.
`default_nettype none
package sudl_pkg;

   localparam int CAPACITY = 16;
   localparam int VAL_W    = 32;
   localparam int ACT_W    = 3;
   localparam int POS_W    = 5;
   localparam int STAT_W   = 3;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

   localparam logic signed [VAL_W-1:0] VALUE_NONE = -32'sd1;

   typedef struct packed {
      logic                    ins_en;
      logic                    rem_en;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
      logic [CNT_W-1:0]        sel_idx;
   } cmd_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } flags_type;

endpackage
`default_nettype wire

[sv/sudl_cell.sv]
// One storage cell of the sorted list chain, holding one entry and shifting with its neighbors.
`default_nettype none
module sudl_cell (
   input  logic                                      clock,
   input  sudl_pkg::cmd_type                         cmd,
   input  logic [sudl_pkg::IDX_W-1:0]                cell_index,
   input  logic                                      left_lt,
   input  logic signed [sudl_pkg::VAL_W-1:0]         left_value,
   input  logic signed [sudl_pkg::VAL_W-1:0]         right_value,
   output sudl_pkg::flags_type                       flags,
   output logic signed [sudl_pkg::VAL_W-1:0]         entry_value,
   output logic signed [sudl_pkg::VAL_W-1:0]         hit_value
);

   localparam int CW = sudl_pkg::CNT_W;

   logic signed [sudl_pkg::VAL_W-1:0] entry_ff;
   logic signed [sudl_pkg::VAL_W-1:0] entry_in;
   logic [CW-1:0]                     idx_ext;
   logic                              occupied;
   logic                              at_tail;

   assign idx_ext  = CW'(cell_index);
   assign occupied = idx_ext < cmd.count;
   assign at_tail  = idx_ext == cmd.count;

   assign flags.lt    = occupied && (entry_ff < cmd.value);
   assign flags.eq    = occupied && (entry_ff == cmd.value);
   assign entry_value = entry_ff;
   assign hit_value   = (idx_ext == cmd.sel_idx) ? entry_ff : '0;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.ins_en) begin
         if (left_lt) begin
            entry_in = left_value;
         end else if (flags.lt || at_tail) begin
            entry_in = cmd.value;
         end
      end else if (cmd.rem_en && (idx_ext >= cmd.sel_idx)) begin
         entry_in = right_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

[sv/sorted_unique_descending_list_top.sv]
// Top level of the sorted descending list of distinct values, built as a chain of cells.
//
//   Channel   Direction   Fields                                  Handshake
//   req       in          action, item_value, position            req_valid / req_stall
//   rsp       out         status, result_value, entry_count       rsp_valid / rsp_stall
//
// Every word is decided in the cycle it is accepted and its result is registered.
// One word per cycle is accepted while req_stall is low; the cell compare and the one-place shift set this.
// A result is registered in the cycle after its word is accepted and holds while rsp_stall is high.
// A stalled result stalls the input side only while the output register is occupied.
// Reset empties the list at once and stalls the input side; no clearing pass is needed.
`default_nettype none
module sorted_unique_descending_list_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [sudl_pkg::ACT_W-1:0]              req_action,
   input  logic signed [sudl_pkg::VAL_W-1:0]       req_item_value,
   input  logic [sudl_pkg::POS_W-1:0]              req_position,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [sudl_pkg::STAT_W-1:0]             rsp_status,
   output logic signed [sudl_pkg::VAL_W-1:0]       rsp_result_value,
   output logic [sudl_pkg::POS_W-1:0]              rsp_entry_count
);

   localparam int CAP = sudl_pkg::CAPACITY;
   localparam int CW  = sudl_pkg::CNT_W;
   localparam int VW  = sudl_pkg::VAL_W;
   localparam int PW  = sudl_pkg::POS_W;
   localparam int IW  = sudl_pkg::IDX_W;

   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    count_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [sudl_pkg::STAT_W-1:0]      status_ff;
   logic [sudl_pkg::STAT_W-1:0]      status_in;
   logic signed [VW-1:0]             result_ff;
   logic signed [VW-1:0]             result_in;

   sudl_pkg::cmd_type                cmd;
   sudl_pkg::flags_type              flags [CAP];
   logic signed [VW-1:0]             cell_value [CAP];
   logic signed [VW-1:0]             cell_hit [CAP];

   logic                             accept;
   logic [CW-1:0]                    pos_ext;
   logic                             pos_ok;
   logic                             found;
   logic                             full;
   logic signed [VW-1:0]             hit_value;
   logic                             is_insert;
   logic                             is_remove;

   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign pos_ext   = CW'(req_position);
   assign pos_ok    = (pos_ext != '0) && (pos_ext <= count_ff);
   assign full      = count_ff == CW'(CAP);
   assign is_insert = req_action == sudl_pkg::ACT_INSERT;
   assign is_remove = req_action == sudl_pkg::ACT_REMOVE;

   always_comb begin
      found     = 1'b0;
      hit_value = '0;
      for (int i = 0; i < CAP; i++) begin
         found     = found | flags[i].eq;
         hit_value = hit_value | cell_hit[i];
      end
   end

   assign cmd.value   = req_item_value;
   assign cmd.count   = count_ff;
   assign cmd.sel_idx = pos_ext - CW'(1);
   assign cmd.ins_en  = accept && is_insert && !found && !full;
   assign cmd.rem_en  = accept && is_remove && pos_ok;

   for (genvar g = 0; g < CAP; g++) begin : g_cell
      sudl_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_index  (IW'(g)),
         .left_lt     ((g == 0) ? 1'b0 : flags[(g == 0) ? 0 : g - 1].lt),
         .left_value  (cell_value[(g == 0) ? 0 : g - 1]),
         .right_value (cell_value[(g == CAP - 1) ? g : g + 1]),
         .flags       (flags[g]),
         .entry_value (cell_value[g]),
         .hit_value   (cell_hit[g])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = sudl_pkg::ST_OK;
      result_in = '0;
      unique case (req_action)
         sudl_pkg::ACT_INSERT: begin
            if (found) begin
               status_in = sudl_pkg::ST_DUP;
            end else if (full) begin
               status_in = sudl_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         sudl_pkg::ACT_REMOVE: begin
            if (pos_ok) begin
               result_in = hit_value;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = sudl_pkg::ST_BADPOS;
               result_in = sudl_pkg::VALUE_NONE;
            end
         end
         sudl_pkg::ACT_READ: begin
            if (pos_ok) begin
               result_in = hit_value;
            end else begin
               status_in = sudl_pkg::ST_BADPOS;
               result_in = sudl_pkg::VALUE_NONE;
            end
         end
         sudl_pkg::ACT_LOOKUP: begin
            if (found) begin
               result_in = req_item_value;
            end else begin
               status_in = sudl_pkg::ST_NOTFOUND;
               result_in = sudl_pkg::VALUE_NONE;
            end
         end
         sudl_pkg::ACT_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = result_ff;
   assign rsp_entry_count  = PW'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAP))
      else $error("Entry count exceeds capacity.");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_entry_count == PW'(count_ff)))
      else $error("Reported entry count differs from the stored count.");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("Insert did not add one entry.");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.rem_en |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("Remove did not take out one entry.");

   a_no_dup_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |-> (!found && !full))
      else $error("Insert enabled for a present value or a full list.");

endmodule
`default_nettype wire
